/* hw/rtl/cpa_pkg.sv */
// cpa_pkg: shared constants, status codes and sequencer states of the clock
// period averager
// no dependencies
package cpa_pkg;

  localparam int WINDOW   = 16;
  localparam int IDX_W    = $clog2(WINDOW);
  localparam int POS_W    = $clog2(WINDOW + 1);
  localparam int SAMPLE_W = 32;
  localparam int FRAC_W   = 16;
  localparam int SUM_W    = SAMPLE_W + $clog2(WINDOW);
  localparam int PROD_W   = SAMPLE_W + FRAC_W;
  localparam int DIV_STEPS = SUM_W;
  localparam int CNT_W    = $clog2(DIV_STEPS);
  localparam int STATUS_W = 2;

  localparam logic [FRAC_W-1:0] FRACTION_RESET = FRAC_W'(6554);

  localparam logic [STATUS_W-1:0] STATUS_ACCEPTED = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_STARTED  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_OUTLIER  = 2'd2;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_READ,
    ST_UPDATE,
    ST_DIVIDE,
    ST_BOUND,
    ST_FINISH
  } state_t;

endpackage

/* hw/rtl/cpa_if.sv */
// cpa_sample_if and cpa_result_if: valid/ready channels of the averager
// depends on cpa_pkg
interface cpa_sample_if;
  logic                          valid;
  logic                          ready;
  logic [cpa_pkg::SAMPLE_W-1:0] period_sample;

  modport source (output valid, output period_sample, input ready);
  modport sink   (input valid, input period_sample, output ready);
endinterface

interface cpa_result_if;
  logic                          valid;
  logic                          ready;
  logic [cpa_pkg::SAMPLE_W-1:0] averaged_period;
  logic [cpa_pkg::STATUS_W-1:0] sample_status;

  modport source (output valid, output averaged_period, output sample_status, input ready);
  modport sink   (input valid, input averaged_period, input sample_status, output ready);
endinterface

/* hw/rtl/clock_period_averager.sv */
// clock_period_averager: moving average of measured clock periods with outlier
// rejection. One sample word in, one result word out. Samples are accepted only
// while the sequencer is idle. An outlier passes through a store read, an update
// and the hand-over to the output register, and the first sample of a collection
// adds a bound multiply before the hand-over; a sample that changes the mean also
// passes through the bit-serial divider (one quotient bit per cycle over the
// 36-bit running sum) between the update and the bound multiply. The hand-over
// waits for a free output, and the next sample can be taken in the cycle after
// the result is loaded, and a finished result waits in the output register while
// the next sample is taken. Depends on cpa_pkg and cpa_if.
module clock_period_averager (
  input  logic                        clk,
  input  logic                        rst,
  cpa_sample_if.sink                  samples,
  cpa_result_if.source                averages,
  input  logic                        cfg_wr_en,
  input  logic [cpa_pkg::FRAC_W-1:0] cfg_wr_data
);
  import cpa_pkg::*;

  state_t state, state_next;

  logic [SAMPLE_W-1:0] period_store [WINDOW];
  logic [SAMPLE_W-1:0] rd_data;

  logic [POS_W-1:0]    position;
  logic                store_full;
  logic [SUM_W-1:0]    running_sum;
  logic [SAMPLE_W-1:0] mean_period;
  logic [SAMPLE_W-1:0] deviation_bound;
  logic [FRAC_W-1:0]   outlier_fraction;
  logic [SAMPLE_W-1:0] sample;
  logic [STATUS_W-1:0] status;
  logic [SAMPLE_W-1:0] result;

  logic [SUM_W-1:0]    div_quot;
  logic [POS_W-1:0]    div_rem;
  logic [POS_W-1:0]    div_count;
  logic [CNT_W-1:0]    step;

  logic                is_start, is_wrap, passed, store_wr;
  logic [SAMPLE_W-1:0] diff;
  logic [IDX_W-1:0]    rd_addr;
  logic [SUM_W-1:0]    sum_next;
  logic [POS_W-1:0]    position_next;
  logic                full_next;
  logic [POS_W-1:0]    count_next;
  logic [POS_W:0]      rem_shift;
  logic                rem_ge;
  logic [SUM_W-1:0]    quot_next;
  logic [PROD_W-1:0]   product;
  logic                out_free;
  logic                last_step;

  // update decode
  always_comb begin
    is_start = (position == '0) && !store_full;
    is_wrap  = (position >= POS_W'(WINDOW));
    diff     = (sample >= mean_period) ? (sample - mean_period) : (mean_period - sample);
    passed   = diff < deviation_bound;
    rd_addr  = is_wrap ? '0 : position[IDX_W-1:0];
    store_wr = (state == ST_UPDATE) && (is_start || is_wrap || passed);

    if (is_start) begin
      sum_next      = SUM_W'(sample);
      position_next = POS_W'(1);
      full_next     = store_full;
    end else if (is_wrap) begin
      sum_next      = running_sum - SUM_W'(rd_data) + SUM_W'(sample);
      position_next = POS_W'(1);
      full_next     = 1'b1;
    end else if (passed) begin
      sum_next      = running_sum - (store_full ? SUM_W'(rd_data) : '0) + SUM_W'(sample);
      position_next = position + POS_W'(1);
      full_next     = store_full;
    end else begin
      sum_next      = '0;
      position_next = '0;
      full_next     = 1'b0;
    end
    count_next = full_next ? POS_W'(WINDOW) : position_next;
  end

  // divider step and bound product
  always_comb begin
    rem_shift = {div_rem, div_quot[SUM_W-1]};
    rem_ge    = rem_shift >= {1'b0, div_count};
    quot_next = {div_quot[SUM_W-2:0], rem_ge};
    last_step = step == CNT_W'(DIV_STEPS - 1);
    product   = PROD_W'(mean_period) * PROD_W'(outlier_fraction);
    out_free  = !averages.valid || averages.ready;
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE:   if (samples.valid) state_next = ST_READ;
      ST_READ:   state_next = ST_UPDATE;
      ST_UPDATE: begin
        if (is_start) begin
          state_next = ST_BOUND;
        end else if (!is_wrap && !passed) begin
          state_next = ST_FINISH;
        end else if (count_next > POS_W'(1)) begin
          state_next = ST_DIVIDE;
        end else begin
          state_next = ST_FINISH;
        end
      end
      ST_DIVIDE: if (last_step) state_next = ST_BOUND;
      ST_BOUND:  state_next = ST_FINISH;
      ST_FINISH: if (out_free) state_next = ST_IDLE;
      default:   state_next = ST_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    samples.ready = (state == ST_IDLE);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // period store
  always_ff @(posedge clk) begin
    if (state == ST_READ) begin
      rd_data <= period_store[rd_addr];
    end
    if (store_wr) begin
      period_store[rd_addr] <= sample;
    end
  end

  // collection state
  always_ff @(posedge clk) begin
    if (rst) begin
      position         <= '0;
      store_full       <= 1'b0;
      running_sum      <= '0;
      mean_period      <= '0;
      deviation_bound  <= '0;
      outlier_fraction <= FRACTION_RESET;
    end else begin
      if (cfg_wr_en) begin
        outlier_fraction <= cfg_wr_data;
      end
      if (state == ST_UPDATE) begin
        position    <= position_next;
        store_full  <= full_next;
        running_sum <= sum_next;
        if (is_start) begin
          mean_period <= sample;
        end
      end
      if (state == ST_DIVIDE && last_step) begin
        mean_period <= quot_next[SAMPLE_W-1:0];
      end
      if (state == ST_BOUND) begin
        deviation_bound <= product[PROD_W-1:FRAC_W];
      end
    end
  end

  // working word and divider
  always_ff @(posedge clk) begin
    if (samples.valid && samples.ready) begin
      sample <= samples.period_sample;
    end
    if (state == ST_UPDATE) begin
      result    <= '0;
      div_quot  <= sum_next;
      div_rem   <= '0;
      div_count <= count_next;
      step      <= '0;
      if (is_start) begin
        status <= STATUS_STARTED;
      end else if (!is_wrap && !passed) begin
        status <= STATUS_OUTLIER;
      end else begin
        status <= STATUS_ACCEPTED;
      end
    end
    if (state == ST_DIVIDE) begin
      div_quot <= quot_next;
      div_rem  <= rem_ge ? POS_W'(rem_shift - {1'b0, div_count}) : rem_shift[POS_W-1:0];
      step     <= step + CNT_W'(1);
      if (last_step) begin
        result <= quot_next[SAMPLE_W-1:0];
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      averages.valid <= 1'b0;
    end else if (state == ST_FINISH && out_free) begin
      averages.valid <= 1'b1;
    end else if (averages.ready) begin
      averages.valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_FINISH && out_free) begin
      averages.averaged_period <= result;
      averages.sample_status   <= status;
    end
  end

`ifndef SYNTHESIS
  a_full_pos: assert property (@(posedge clk) disable iff (rst)
    store_full |-> (position != '0))
    else $error("store full with write position zero");

  a_pos_range: assert property (@(posedge clk) disable iff (rst)
    position <= POS_W'(WINDOW))
    else $error("write position beyond window");

  a_accept_read: assert property (@(posedge clk) disable iff (rst)
    (samples.valid && samples.ready) |=> (state == ST_READ))
    else $error("accepted word did not start a store read");

  a_no_code3: assert property (@(posedge clk) disable iff (rst)
    averages.valid |-> (averages.sample_status != 2'd3))
    else $error("reserved status code on output");

  a_restart_zero: assert property (@(posedge clk) disable iff (rst)
    (averages.valid && (averages.sample_status != STATUS_ACCEPTED))
      |-> (averages.averaged_period == '0))
    else $error("non-zero mean with restart status");

  a_div_count: assert property (@(posedge clk) disable iff (rst)
    (state == ST_DIVIDE) |-> (div_count > POS_W'(1)))
    else $error("divider started with count below two");
`endif

endmodule
